FILE: src/can_signal_field_codec_unit_macros.svh
// ----------------------------------------------------------------------------
// CAN signal field codec: assertion macros
// Shared concurrent assertion forms, clocked on i_clk, off during reset.
// ----------------------------------------------------------------------------
`ifndef CAN_SIGNAL_FIELD_CODEC_UNIT_MACROS_SVH
`define CAN_SIGNAL_FIELD_CODEC_UNIT_MACROS_SVH

// same-cycle implication
`define CSFC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("csfc assertion failed");

// next-cycle implication
`define CSFC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("csfc assertion failed");

`endif

FILE: src/csfc_pkg.sv
// ----------------------------------------------------------------------------
// CAN signal field codec package
// Shared constants, register indexes, types and helpers.
// ----------------------------------------------------------------------------
`default_nettype none

package csfc_pkg;

    localparam int FRAME_BYTES = 8;
    localparam int FRAME_BITS  = FRAME_BYTES * 8;
    localparam logic [63:0] FRAME_MASK = {64{1'b1}} >> (64 - FRAME_BITS);

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    localparam logic [CFG_IDX_W-1:0] REG_SIG_START  = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BIT_LENGTH = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_MOTOROLA   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_SIGNED     = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SCALE      = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_OFFSET     = 3'd5;

    localparam logic MODE_EXTRACT = 1'b0;
    localparam logic MODE_INSERT  = 1'b1;

    localparam int QDEPTH = 4;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    typedef struct packed {
        logic [5:0]         sig_start;
        logic [6:0]         bit_length;
        logic               motorola_order;
        logic               signed_field;
        logic [31:0]        scale_q16;
        logic signed [47:0] offset_q16;
    } t_cfg;

    typedef struct packed {
        logic        mode;
        logic [63:0] frame_out;
        logic [63:0] raw;
        logic        neg;
        logic [63:0] mag;
    } t_item;

    function automatic logic [63:0] rev64(input logic [63:0] a);
        logic [63:0] r;
        for (int k = 0; k < 64; k++) begin
            r[k] = a[63-k];
        end
        return r;
    endfunction

endpackage

`default_nettype wire

FILE: src/csfc_front.sv
// ----------------------------------------------------------------------------
// CAN signal field codec: front end
// Gathers or scatters the signal bits and prepares the magnitude for scaling.
// ----------------------------------------------------------------------------
`default_nettype none

module csfc_front (
    input  wire csfc_pkg::t_cfg  i_cfg,
    input  wire                  i_mode,
    input  wire [63:0]           i_frame,
    input  wire [63:0]           i_insert_value,
    output csfc_pkg::t_item      o_item
);
    import csfc_pkg::*;

    logic [6:0]  len;
    logic [5:0]  shamt;
    logic [5:0]  sidx;
    logic [63:0] len_mask;
    logic [63:0] fwalk;
    logic [63:0] raw;
    logic [63:0] fmask;
    logic [63:0] vshift;
    logic [63:0] wmask;
    logic [63:0] wdata;
    logic        neg;

    always_comb begin
        len = (i_cfg.bit_length > 7'd64) ? 7'd64 : i_cfg.bit_length;
        if (i_cfg.motorola_order && ({1'b0, i_cfg.sig_start} >= 7'(FRAME_BITS))) begin
            len = 7'd0;
        end
        len_mask = len[6] ? {64{1'b1}} : ~({64{1'b1}} << len[5:0]);
        shamt    = i_cfg.motorola_order ? (6'd63 - i_cfg.sig_start) : i_cfg.sig_start;
        fwalk    = i_cfg.motorola_order ? rev64(i_frame & FRAME_MASK) : (i_frame & FRAME_MASK);
        raw      = (fwalk >> shamt) & len_mask;
        fmask    = len_mask << shamt;
        vshift   = i_insert_value << shamt;
        wmask    = (i_cfg.motorola_order ? rev64(fmask) : fmask) & FRAME_MASK;
        wdata    = i_cfg.motorola_order ? rev64(vshift) : vshift;
        sidx     = 6'(len - 7'd1);
        neg      = i_cfg.signed_field && (len != 7'd0) && raw[sidx];

        o_item.mode = i_mode;
        o_item.neg  = neg;
        o_item.raw  = raw;
        o_item.mag  = neg ? (~(raw | ~len_mask) + 64'd1) : raw;
        if (i_mode == MODE_INSERT) begin
            o_item.frame_out = (i_frame & ~wmask) | (wdata & wmask);
        end else begin
            o_item.frame_out = i_frame;
        end
    end

endmodule

`default_nettype wire

FILE: src/csfc_queue.sv
// ----------------------------------------------------------------------------
// CAN signal field codec: item queue
// Short first-in first-out store between the front end and the scaler.
// ----------------------------------------------------------------------------
`default_nettype none

`include "can_signal_field_codec_unit_macros.svh"

module csfc_queue (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_push,
    input  wire csfc_pkg::t_item i_item,
    output logic                 o_full,
    input  wire                  i_pop,
    output logic                 o_not_empty,
    output csfc_pkg::t_item      o_item
);
    import csfc_pkg::*;

    t_item             r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wptr, n_wptr;
    logic [QPTR_W-1:0] r_rptr, n_rptr;
    logic [QCNT_W-1:0] r_count, n_count;
    logic              do_pop;

    assign o_full      = (r_count == QCNT_W'(QDEPTH));
    assign o_not_empty = (r_count != '0);
    assign o_item      = r_mem[r_rptr];
    assign do_pop      = i_pop && o_not_empty;

    always_comb begin
        n_wptr  = i_push ? QPTR_W'(r_wptr + 1'b1) : r_wptr;
        n_rptr  = do_pop ? QPTR_W'(r_rptr + 1'b1) : r_rptr;
        n_count = r_count;
        if (i_push && !do_pop) begin
            n_count = QCNT_W'(r_count + 1'b1);
        end else if (!i_push && do_pop) begin
            n_count = QCNT_W'(r_count - 1'b1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wptr  <= '0;
            r_rptr  <= '0;
            r_count <= '0;
        end else begin
            r_wptr  <= n_wptr;
            r_rptr  <= n_rptr;
            r_count <= n_count;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wptr] <= i_item;
        end
    end

    `CSFC_ASSERT_NOW(a_no_push_when_full, i_push, !o_full)
    `CSFC_ASSERT_NEXT(a_push_only_grows, i_push && !do_pop, r_count == $past(r_count) + 1'b1)
    `CSFC_ASSERT_NOW(a_ptrs_track_count, r_count == '0, r_wptr == r_rptr)

endmodule

`default_nettype wire

FILE: src/csfc_back.sv
// ----------------------------------------------------------------------------
// CAN signal field codec: scaler
// Pipelined raw * scale + offset in Q16 with saturation to signed 64 bits.
// ----------------------------------------------------------------------------
`default_nettype none

`include "can_signal_field_codec_unit_macros.svh"

module csfc_back (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire csfc_pkg::t_cfg  i_cfg,
    input  wire                  i_valid,
    input  wire csfc_pkg::t_item i_item,
    output logic                 o_strobe,
    output logic [63:0]          o_frame_out,
    output logic [63:0]          o_raw_field,
    output logic signed [63:0]   o_physical_q16,
    output logic                 o_saturated
);
    import csfc_pkg::*;

    localparam logic signed [63:0] PHYS_MAX = {1'b0, {63{1'b1}}};
    localparam logic signed [63:0] PHYS_MIN = {1'b1, {63{1'b0}}};

    // stage 1: partial products
    logic        r_v1, r_m1, r_neg1;
    logic [63:0] r_f1, r_raw1;
    logic [63:0] r_plo, r_phi;
    // stage 2: magnitude product
    logic        r_v2, r_m2, r_neg2;
    logic [63:0] r_f2, r_raw2;
    logic [95:0] r_prod;
    // stage 3: signed product
    logic               r_v3, r_m3;
    logic [63:0]        r_f3, r_raw3;
    logic signed [97:0] r_sprod;
    // output stage
    logic               r_v4, r_sat4;
    logic [63:0]        r_f4, r_raw4;
    logic signed [63:0] r_phys4;

    logic signed [97:0] sum;
    logic               fits;

    always_comb begin
        sum  = r_sprod + 98'(i_cfg.offset_q16);
        fits = (sum[97:63] == '0) || (sum[97:63] == '1);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
            r_v3 <= r_v2;
            r_v4 <= r_v3;
        end
    end

    always_ff @(posedge i_clk) begin
        r_m1   <= i_item.mode;
        r_neg1 <= i_item.neg;
        r_f1   <= i_item.frame_out;
        r_raw1 <= i_item.raw;
        r_plo  <= 64'(i_item.mag[31:0]) * 64'(i_cfg.scale_q16);
        r_phi  <= 64'(i_item.mag[63:32]) * 64'(i_cfg.scale_q16);

        r_m2   <= r_m1;
        r_neg2 <= r_neg1;
        r_f2   <= r_f1;
        r_raw2 <= r_raw1;
        r_prod <= {32'd0, r_plo} + {r_phi, 32'd0};

        r_m3    <= r_m2;
        r_f3    <= r_f2;
        r_raw3  <= r_raw2;
        r_sprod <= r_neg2 ? -$signed({2'b00, r_prod}) : $signed({2'b00, r_prod});

        r_f4 <= r_f3;
        if (r_m3 == MODE_INSERT) begin
            r_raw4  <= '0;
            r_phys4 <= '0;
            r_sat4  <= 1'b0;
        end else begin
            r_raw4  <= r_raw3;
            r_phys4 <= fits ? sum[63:0] : (sum[97] ? PHYS_MIN : PHYS_MAX);
            r_sat4  <= !fits;
        end
    end

    assign o_strobe       = r_v4;
    assign o_frame_out    = r_f4;
    assign o_raw_field    = r_raw4;
    assign o_physical_q16 = r_phys4;
    assign o_saturated    = r_sat4;

    `CSFC_ASSERT_NOW(a_sat_at_limit, r_v4 && r_sat4, r_phys4 == PHYS_MAX || r_phys4 == PHYS_MIN)
    `CSFC_ASSERT_NEXT(a_valid_flows, r_v1, r_v2)

endmodule

`default_nettype wire

FILE: src/can_signal_field_codec_unit.sv
// ----------------------------------------------------------------------------
// CAN signal field codec unit
// Extracts, scales or inserts one signal in an 8-byte CAN payload.
// ----------------------------------------------------------------------------
// Command channel: a word (mode, frame, insert value) is taken on a clock edge
// with start high and busy low. Extract mode returns the gathered raw bits
// and raw * scale + offset in Q16, clipped to signed 64 bits with a flag;
// insert mode returns the frame with the value written into the signal bits.
// Results: one per word, held on the o_ ports for one cycle with o_strobe
// high, once the word has passed the queue write, the two multiplier stages,
// the sign stage and the offset add and clip. The receiver cannot stall.
// Throughput: one word per cycle; the front end is a single combinational
// shift/mask stage and the scaler is fully pipelined, so the 4-entry queue
// between them never fills and busy stays low.
// Configuration: a separate write channel (i_cfg_valid, o_cfg_ready always
// high, register index and data); write only while no word is in flight.
// Reset (synchronous, active low) empties the queue and pipeline and loads
// start bit 0, length 8, Intel order, unsigned, scale 1.0, offset 0.
// ----------------------------------------------------------------------------
`default_nettype none

module can_signal_field_codec_unit (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    input  wire                               start,
    output logic                              busy,
    input  wire                               i_mode,
    input  wire [63:0]                        i_frame,
    input  wire [63:0]                        i_insert_value,
    output logic                              o_strobe,
    output logic [63:0]                       o_frame_out,
    output logic [63:0]                       o_raw_field,
    output logic signed [63:0]                o_physical_q16,
    output logic                              o_saturated,
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire [csfc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [csfc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);
    import csfc_pkg::*;

    t_cfg  r_cfg;
    t_item front_item;
    t_item queue_item;
    logic  q_full;
    logic  q_not_empty;
    logic  push;

    assign o_cfg_ready = 1'b1;
    assign busy        = q_full;
    assign push        = start && !q_full;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sig_start      <= 6'd0;
            r_cfg.bit_length     <= 7'd8;
            r_cfg.motorola_order <= 1'b0;
            r_cfg.signed_field   <= 1'b0;
            r_cfg.scale_q16      <= 32'd65536;
            r_cfg.offset_q16     <= '0;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_SIG_START:  r_cfg.sig_start      <= i_cfg_data[5:0];
                REG_BIT_LENGTH: r_cfg.bit_length     <= i_cfg_data[6:0];
                REG_MOTOROLA:   r_cfg.motorola_order <= i_cfg_data[0];
                REG_SIGNED:     r_cfg.signed_field   <= i_cfg_data[0];
                REG_SCALE:      r_cfg.scale_q16      <= i_cfg_data[31:0];
                REG_OFFSET:     r_cfg.offset_q16     <= $signed(i_cfg_data[47:0]);
                default: ;
            endcase
        end
    end

    csfc_front u_front (
        .i_cfg          (r_cfg),
        .i_mode         (i_mode),
        .i_frame        (i_frame),
        .i_insert_value (i_insert_value),
        .o_item         (front_item)
    );

    csfc_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (push),
        .i_item      (front_item),
        .o_full      (q_full),
        .i_pop       (1'b1),
        .o_not_empty (q_not_empty),
        .o_item      (queue_item)
    );

    csfc_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cfg          (r_cfg),
        .i_valid        (q_not_empty),
        .i_item         (queue_item),
        .o_strobe       (o_strobe),
        .o_frame_out    (o_frame_out),
        .o_raw_field    (o_raw_field),
        .o_physical_q16 (o_physical_q16),
        .o_saturated    (o_saturated)
    );

endmodule

`default_nettype wire
